// ----- rtl/core/mppt_pkg.sv -----
// Package of the MPPT core: control word format, microprogram and shared constants.
package mppt_pkg;

    // Micro-operations executed by the datapath.
    typedef enum logic [2:0] {
        U_WAIT = 3'd0,
        U_SET  = 3'd1,
        U_LDSP = 3'd2,
        U_MUL  = 3'd3,
        U_DIV  = 3'd4,
        U_EMIT = 3'd5,
        U_BR   = 3'd6
    } uop_t;

    typedef logic [2:0] arg_t;
    typedef logic [4:0] upc_t;

    typedef struct packed {
        uop_t op;
        arg_t arg;
        upc_t nxt;
    } cw_t;

    // Tracker mode and local-step phase.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_SCAN  = 3'b010,
        MODE_LOCAL = 3'b100
    } mode_t;

    typedef enum logic [2:0] {
        PH_CENTER = 3'b001,
        PH_UP     = 3'b010,
        PH_DOWN   = 3'b100
    } phase_t;

    // Input action codes.
    localparam logic [1:0] ACT_SCAN    = 2'd0;
    localparam logic [1:0] ACT_LOCAL   = 2'd1;
    localparam logic [1:0] ACT_MEASURE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCAN_POINTS  = 2'd0;
    localparam logic [1:0] CFG_TIMER_PERIOD = 2'd1;
    localparam logic [1:0] CFG_PULSE_MAX    = 2'd2;
    localparam logic [1:0] CFG_PULSE_MIN    = 2'd3;

    // Arguments of U_SET.
    localparam arg_t SET_SCAN_INIT  = 3'd0;
    localparam arg_t SET_IDLE       = 3'd1;
    localparam arg_t SET_SCAN_MEAS  = 3'd2;
    localparam arg_t SET_LOCAL_INIT = 3'd3;
    localparam arg_t SET_PH_CENTER  = 3'd4;
    localparam arg_t SET_PH_UP      = 3'd5;
    localparam arg_t SET_PH_DOWN    = 3'd6;

    // Arguments of U_LDSP: source of the next setpoint.
    localparam arg_t SPS_SCAN   = 3'd0;
    localparam arg_t SPS_BEST   = 3'd1;
    localparam arg_t SPS_CENTER = 3'd2;
    localparam arg_t SPS_UP     = 3'd3;
    localparam arg_t SPS_DOWN   = 3'd4;
    localparam arg_t SPS_DEC    = 3'd5;
    localparam arg_t SPS_INC    = 3'd6;

    // Arguments of U_DIV.
    localparam arg_t DIV_STEP  = 3'd0;
    localparam arg_t DIV_PULSE = 3'd1;

    // Arguments of U_EMIT: how wants_measure and last are formed.
    localparam arg_t EMK_MEAS  = 3'd0;
    localparam arg_t EMK_FINAL = 3'd1;
    localparam arg_t EMK_CTR   = 3'd2;
    localparam arg_t EMK_DEC   = 3'd3;

    // Arguments of U_BR.
    localparam arg_t CND_SCAN_MORE = 3'd0;
    localparam arg_t CND_NO_DOWN   = 3'd1;
    localparam arg_t CND_NO_UP     = 3'd2;

    // Entry points of the microprogram.
    localparam upc_t PC_WAIT        = 5'd0;
    localparam upc_t PC_SCAN_START  = 5'd1;
    localparam upc_t PC_SCAN_TEST   = 5'd3;
    localparam upc_t PC_SCAN_POINT  = 5'd6;
    localparam upc_t PC_MEAS_TAIL   = 5'd7;
    localparam upc_t PC_FINAL_TAIL  = 5'd10;
    localparam upc_t PC_SCAN_MEAS   = 5'd13;
    localparam upc_t PC_LOCAL_START = 5'd14;
    localparam upc_t PC_PH_CENTER   = 5'd16;
    localparam upc_t PC_PH_UP       = 5'd18;
    localparam upc_t PC_PH_DOWN     = 5'd20;
    localparam upc_t PC_TEST_UP     = 5'd30;

    // Arithmetic constants.
    localparam logic [15:0] SP_RESET     = 16'd288;
    localparam logic [15:0] PROBE_STEP   = 16'd8;
    localparam logic [15:0] PROBE_FLOOR  = 16'd18;
    localparam logic [15:0] PROBE_KNEE   = 16'd34;
    localparam logic [9:0]  DUTY_FULL    = 10'd1000;
    localparam logic [9:0]  SCAN_FIRST   = 10'd5;
    localparam logic [10:0] THIRD_MUL    = 11'd683;
    localparam int          THIRD_SHIFT  = 11;
    localparam logic [28:0] RECIP_1000   = 29'd274877907;
    localparam int          RECIP_SHIFT  = 38;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [15:0] PMAX_RESET   = 16'd950;
    localparam logic [9:0]  POINTS_RESET = 10'd168;
    localparam logic [5:0]  DIV_STEPS    = 6'd32;

    function automatic cw_t mk_cw(input uop_t op, input arg_t arg, input upc_t nxt);
        cw_t w;
        w.op  = op;
        w.arg = arg;
        w.nxt = nxt;
        return w;
    endfunction

    // The microprogram. U_BR jumps to nxt when its condition holds, else falls through.
    function automatic cw_t ucode(input upc_t addr);
        cw_t w;
        unique case (addr)
            5'd0:  w = mk_cw(U_WAIT, 3'd0,           PC_WAIT);
            5'd1:  w = mk_cw(U_DIV,  DIV_STEP,       5'd2);
            5'd2:  w = mk_cw(U_SET,  SET_SCAN_INIT,  PC_SCAN_TEST);
            5'd3:  w = mk_cw(U_BR,   CND_SCAN_MORE,  PC_SCAN_POINT);
            5'd4:  w = mk_cw(U_SET,  SET_IDLE,       5'd5);
            5'd5:  w = mk_cw(U_LDSP, SPS_BEST,       PC_FINAL_TAIL);
            5'd6:  w = mk_cw(U_LDSP, SPS_SCAN,       PC_MEAS_TAIL);
            5'd7:  w = mk_cw(U_MUL,  3'd0,           5'd8);
            5'd8:  w = mk_cw(U_DIV,  DIV_PULSE,      5'd9);
            5'd9:  w = mk_cw(U_EMIT, EMK_MEAS,       PC_WAIT);
            5'd10: w = mk_cw(U_MUL,  3'd0,           5'd11);
            5'd11: w = mk_cw(U_DIV,  DIV_PULSE,      5'd12);
            5'd12: w = mk_cw(U_EMIT, EMK_FINAL,      PC_WAIT);
            5'd13: w = mk_cw(U_SET,  SET_SCAN_MEAS,  PC_SCAN_TEST);
            5'd14: w = mk_cw(U_SET,  SET_LOCAL_INIT, 5'd15);
            5'd15: w = mk_cw(U_LDSP, SPS_CENTER,     PC_MEAS_TAIL);
            5'd16: w = mk_cw(U_SET,  SET_PH_CENTER,  5'd17);
            5'd17: w = mk_cw(U_LDSP, SPS_UP,         PC_MEAS_TAIL);
            5'd18: w = mk_cw(U_SET,  SET_PH_UP,      5'd19);
            5'd19: w = mk_cw(U_LDSP, SPS_DOWN,       PC_MEAS_TAIL);
            5'd20: w = mk_cw(U_SET,  SET_PH_DOWN,    5'd21);
            5'd21: w = mk_cw(U_LDSP, SPS_CENTER,     5'd22);
            5'd22: w = mk_cw(U_MUL,  3'd0,           5'd23);
            5'd23: w = mk_cw(U_DIV,  DIV_PULSE,      5'd24);
            5'd24: w = mk_cw(U_EMIT, EMK_CTR,        5'd25);
            5'd25: w = mk_cw(U_BR,   CND_NO_DOWN,    PC_TEST_UP);
            5'd26: w = mk_cw(U_LDSP, SPS_DEC,        5'd27);
            5'd27: w = mk_cw(U_MUL,  3'd0,           5'd28);
            5'd28: w = mk_cw(U_DIV,  DIV_PULSE,      5'd29);
            5'd29: w = mk_cw(U_EMIT, EMK_DEC,        PC_TEST_UP);
            5'd30: w = mk_cw(U_BR,   CND_NO_UP,      PC_WAIT);
            5'd31: w = mk_cw(U_LDSP, SPS_INC,        PC_FINAL_TAIL);
            default: w = mk_cw(U_WAIT, 3'd0, PC_WAIT);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/mppt_sweep_and_hill_climb_core.sv -----
// Top level of the MPPT core: microcoded sequencer, step divider, reciprocal multiplier and output register.
//
// This core tracks the maximum power point of a solar source. Action 0 on the input
// stream starts a global sweep: the step is 1000 / scan_points per mille and indices
// from 5 upwards are visited while below scan_points / 3; each visited setpoint asks
// for one power measurement (action 2), and at the end the setpoint with the strictly
// largest power is settled on. Action 1 starts a perturb-and-observe step: the centre,
// centre + 8 and a low probe (centre - 8, or 18 when the centre is below 34) are
// measured, the centre is restored, then the setpoint moves one per mille down and/or
// up. Every result carries the setpoint, the timer compare value
// setpoint * timer_period / 1000 clamped to pulse_max and then pulse_min, a flag that
// asks for a measurement, and tlast on the final result of a transaction. A measurement
// while idle, and action 3, give no result. Control is a 32-word microprogram. The
// division by 1000 is a multiplication by a scaled reciprocal, so a result passes through
// the load of the setpoint, the product, the quotient, the clamp and the hand-over to
// the output register. The start of a sweep takes longest, because the step size comes
// from a 32-step restoring divider, and a result waits while the output register holds
// a result that has not been taken. One transaction is worked on at a time; the next
// one is taken once the program has returned to its wait word, while the last result
// may still wait in the output register.
module mppt_sweep_and_hill_climb_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] power (signed)
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] setpoint, [31:16] pulse
    output logic [0:0]  m_axis_tuser,   // [0] wants_measure
    output logic        m_axis_tlast
);
    import mppt_pkg::*;

    // Configuration registers
    logic [9:0]  points_reg;
    logic [15:0] period_reg;
    logic [15:0] pmax_reg;
    logic [15:0] pmin_reg;

    // Sequencer and tracker state
    upc_t               upc_reg;
    mode_t              mode_reg;
    phase_t             phase_reg;
    logic [9:0]         scan_index_reg;
    logic [9:0]         scan_end_reg;
    logic [9:0]         step_size_reg;
    logic [9:0]         best_index_reg;
    logic signed [15:0] best_power_reg;
    logic [15:0]        cur_sp_reg;
    logic [15:0]        center_reg;
    logic signed [15:0] pwr_center_reg;
    logic signed [15:0] pwr_up_reg;
    logic               down_better_reg;
    logic               up_better_reg;
    logic               div_busy_reg;
    logic               div_done_reg;
    logic [5:0]         div_cnt_reg;
    logic               out_valid_reg;

    // Datapath registers
    logic signed [15:0] power_in_reg;
    logic [15:0]        sp_reg;
    logic [31:0]        prod_reg;
    logic [15:0]        pulse_reg;
    logic [31:0]        div_quo_reg;
    logic [9:0]         div_rem_reg;
    logic [9:0]         div_den_reg;
    logic [15:0]        out_sp_reg;
    logic [15:0]        out_pulse_reg;
    logic               out_wants_reg;
    logic               out_last_reg;

    cw_t         cw;
    logic        in_accept;
    logic        out_load;
    upc_t        dispatch_pc;
    logic        br_taken;
    logic        emit_wants;
    logic        emit_last;
    logic [9:0]  pts_eff;
    logic [20:0] third_prod;
    logic [19:0] scan_prod;
    logic [19:0] best_prod;
    logic [15:0] sp_sel;
    logic [11:0] div_trial;
    logic [60:0] recip_prod;
    logic [31:0] pulse_hi;
    logic [15:0] pulse_clamped;

    assign cw            = ucode(upc_reg);
    assign s_axis_tready = (cw.op == U_WAIT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = (cw.op == U_EMIT) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pulse_reg, out_sp_reg};
    assign m_axis_tuser  = out_wants_reg;
    assign m_axis_tlast  = out_last_reg;

    // A point count of zero behaves as one; a third is taken by reciprocal multiplication.
    assign pts_eff    = (points_reg == 10'd0) ? 10'd1 : points_reg;
    assign third_prod = pts_eff * THIRD_MUL;
    assign scan_prod  = scan_index_reg * step_size_reg;
    assign best_prod  = best_index_reg * step_size_reg;

    // One restoring division step: shift in the next dividend bit and try to subtract.
    assign div_trial = {1'b0, div_rem_reg, div_quo_reg[31]} - {2'b00, div_den_reg};

    // Division of the timer product by 1000: the reciprocal 2^38 / 1000 is rounded up, and
    // the rounding error stays below one unit of the quotient for every 32-bit product.
    assign recip_prod = prod_reg * RECIP_1000;

    // The clamp works on the full quotient before it is narrowed.
    assign pulse_hi      = (div_quo_reg > {16'd0, pmax_reg}) ? {16'd0, pmax_reg} : div_quo_reg;
    assign pulse_clamped = (pulse_hi[15:0] < pmin_reg || pulse_hi[31:16] != 16'd0)
                         ? ((pulse_hi < {16'd0, pmin_reg}) ? pmin_reg : pulse_hi[15:0])
                         : pulse_hi[15:0];

    // Entry point for a newly accepted transaction.
    always_comb
    begin
        dispatch_pc = PC_WAIT;
        case (s_axis_tuser)
            ACT_SCAN:  dispatch_pc = PC_SCAN_START;
            ACT_LOCAL: dispatch_pc = PC_LOCAL_START;
            ACT_MEASURE:
            begin
                unique case (mode_reg)
                    MODE_SCAN:  dispatch_pc = PC_SCAN_MEAS;
                    MODE_LOCAL:
                    begin
                        unique case (phase_reg)
                            PH_CENTER: dispatch_pc = PC_PH_CENTER;
                            PH_UP:     dispatch_pc = PC_PH_UP;
                            PH_DOWN:   dispatch_pc = PC_PH_DOWN;
                            default:   dispatch_pc = PC_WAIT;
                        endcase
                    end
                    default: dispatch_pc = PC_WAIT;
                endcase
            end
            default: dispatch_pc = PC_WAIT;
        endcase
    end

    always_comb
    begin
        case (cw.arg)
            CND_SCAN_MORE: br_taken = (scan_index_reg < scan_end_reg);
            CND_NO_DOWN:   br_taken = !down_better_reg;
            CND_NO_UP:     br_taken = !up_better_reg;
            default:       br_taken = 1'b1;
        endcase
    end

    always_comb
    begin
        case (cw.arg)
            EMK_MEAS:
            begin
                emit_wants = 1'b1;
                emit_last  = 1'b1;
            end
            EMK_CTR:
            begin
                emit_wants = 1'b0;
                emit_last  = !down_better_reg && !up_better_reg;
            end
            EMK_DEC:
            begin
                emit_wants = 1'b0;
                emit_last  = !up_better_reg;
            end
            default:
            begin
                emit_wants = 1'b0;
                emit_last  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        case (cw.arg)
            SPS_SCAN:   sp_sel = scan_prod[15:0];
            SPS_BEST:   sp_sel = best_prod[15:0];
            SPS_UP:     sp_sel = center_reg + PROBE_STEP;
            SPS_DOWN:   sp_sel = (center_reg < PROBE_KNEE) ? PROBE_FLOOR
                                                            : center_reg - PROBE_STEP;
            SPS_DEC:    sp_sel = center_reg - 16'd1;
            SPS_INC:    sp_sel = center_reg + 16'd1;
            default:    sp_sel = center_reg;
        endcase
    end

    // Control and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg      <= POINTS_RESET;
            period_reg      <= PERIOD_RESET;
            pmax_reg        <= PMAX_RESET;
            pmin_reg        <= 16'd0;
            upc_reg         <= PC_WAIT;
            mode_reg        <= MODE_IDLE;
            phase_reg       <= PH_CENTER;
            scan_index_reg  <= 10'd0;
            scan_end_reg    <= 10'd0;
            step_size_reg   <= 10'd0;
            best_index_reg  <= 10'd0;
            best_power_reg  <= 16'sd0;
            cur_sp_reg      <= SP_RESET;
            center_reg      <= SP_RESET;
            pwr_center_reg  <= 16'sd0;
            pwr_up_reg      <= 16'sd0;
            down_better_reg <= 1'b0;
            up_better_reg   <= 1'b0;
            div_busy_reg    <= 1'b0;
            div_done_reg    <= 1'b0;
            div_cnt_reg     <= 6'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCAN_POINTS:  points_reg <= cfg_data[9:0];
                    CFG_TIMER_PERIOD: period_reg <= cfg_data;
                    CFG_PULSE_MAX:    pmax_reg   <= cfg_data;
                    CFG_PULSE_MIN:    pmin_reg   <= cfg_data;
                    default:          pmin_reg   <= pmin_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (cw.op)
                U_WAIT:
                begin
                    if (in_accept)
                    begin
                        upc_reg <= dispatch_pc;
                    end
                end
                U_SET:
                begin
                    upc_reg <= cw.nxt;
                    case (cw.arg)
                        SET_SCAN_INIT:
                        begin
                            scan_end_reg   <= third_prod[20:THIRD_SHIFT];
                            scan_index_reg <= SCAN_FIRST;
                            best_power_reg <= 16'sd0;
                            mode_reg       <= MODE_SCAN;
                        end
                        SET_IDLE:
                        begin
                            mode_reg <= MODE_IDLE;
                        end
                        SET_SCAN_MEAS:
                        begin
                            if (power_in_reg > best_power_reg)
                            begin
                                best_power_reg <= power_in_reg;
                                best_index_reg <= scan_index_reg;
                            end
                            scan_index_reg <= scan_index_reg + 10'd1;
                        end
                        SET_LOCAL_INIT:
                        begin
                            center_reg <= cur_sp_reg;
                            phase_reg  <= PH_CENTER;
                            mode_reg   <= MODE_LOCAL;
                        end
                        SET_PH_CENTER:
                        begin
                            pwr_center_reg <= power_in_reg;
                            phase_reg      <= PH_UP;
                        end
                        SET_PH_UP:
                        begin
                            pwr_up_reg <= power_in_reg;
                            phase_reg  <= PH_DOWN;
                        end
                        SET_PH_DOWN:
                        begin
                            mode_reg        <= MODE_IDLE;
                            phase_reg       <= PH_CENTER;
                            down_better_reg <= (pwr_center_reg < power_in_reg);
                            up_better_reg   <= (pwr_center_reg < pwr_up_reg);
                        end
                        default:
                        begin
                            mode_reg <= mode_reg;
                        end
                    endcase
                end
                U_LDSP, U_MUL:
                begin
                    upc_reg <= cw.nxt;
                end
                U_DIV:
                begin
                    if (div_done_reg)
                    begin
                        div_done_reg <= 1'b0;
                        upc_reg      <= cw.nxt;
                        if (cw.arg == DIV_STEP)
                        begin
                            step_size_reg <= div_quo_reg[9:0];
                        end
                    end
                    else if (div_busy_reg)
                    begin
                        div_cnt_reg <= div_cnt_reg - 6'd1;
                        if (div_cnt_reg == 6'd1)
                        begin
                            div_busy_reg <= 1'b0;
                            div_done_reg <= 1'b1;
                        end
                    end
                    else if (cw.arg == DIV_STEP)
                    begin
                        div_busy_reg <= 1'b1;
                        div_cnt_reg  <= DIV_STEPS;
                    end
                    else
                    begin
                        // The pulse quotient is ready after the reciprocal multiplication.
                        div_done_reg <= 1'b1;
                    end
                end
                U_EMIT:
                begin
                    if (out_load)
                    begin
                        cur_sp_reg <= sp_reg;
                        upc_reg    <= cw.nxt;
                    end
                end
                U_BR:
                begin
                    upc_reg <= br_taken ? cw.nxt : upc_reg + 5'd1;
                end
                default:
                begin
                    upc_reg <= PC_WAIT;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            power_in_reg <= $signed(s_axis_tdata);
        end

        if (cw.op == U_LDSP)
        begin
            sp_reg <= sp_sel;
        end

        if (cw.op == U_MUL)
        begin
            prod_reg <= sp_reg * period_reg;
        end

        if (cw.op == U_DIV)
        begin
            if (div_done_reg)
            begin
                pulse_reg <= pulse_clamped;
            end
            else if (div_busy_reg)
            begin
                if (!div_trial[11])
                begin
                    div_rem_reg <= div_trial[9:0];
                    div_quo_reg <= {div_quo_reg[30:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= {div_rem_reg[8:0], div_quo_reg[31]};
                    div_quo_reg <= {div_quo_reg[30:0], 1'b0};
                end
            end
            else
            begin
                div_rem_reg <= 10'd0;
                if (cw.arg == DIV_STEP)
                begin
                    div_quo_reg <= {22'd0, DUTY_FULL};
                    div_den_reg <= pts_eff;
                end
                else
                begin
                    div_quo_reg <= {9'd0, recip_prod[60:RECIP_SHIFT]};
                end
            end
        end

        if (out_load)
        begin
            out_sp_reg    <= sp_reg;
            out_pulse_reg <= pulse_reg;
            out_wants_reg <= emit_wants;
            out_last_reg  <= emit_last;
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench of the MPPT sweep and hill-climb core with its own duty predictor.
module testbench;
    import mppt_pkg::*;

    // The fourth action code has no meaning to the core and must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    // The slowest transaction is the start of a sweep.
    localparam int SETTLE_CYCLES = 150;
    localparam int IDLE_PCT = 22;
    localparam int MAX_REPORTS = 10;

    // One duty result as the core should present it on the result stream.
    typedef struct packed {
        logic [15:0] setpoint;
        logic [15:0] pulse;
        logic        wants_measure;
        logic        last;
    } duty_result_t;

    // The scoreboard keeps a private copy of the tracker state and configuration. Each
    // accepted input transaction is run through it to queue the duty results it causes,
    // and each result leaving the core is compared with the oldest queued one.
    class mppt_scoreboard;
        bit [9:0]  scan_points;
        bit [15:0] timer_period;
        bit [15:0] pulse_max;
        bit [15:0] pulse_min;

        mode_t     mode;
        phase_t    phase;
        bit [9:0]  scan_idx;
        bit [9:0]  scan_end;
        bit [9:0]  step;
        bit [9:0]  best_idx;
        bit signed [15:0] best_power;
        bit signed [15:0] power_centre;
        bit signed [15:0] power_up;
        bit [15:0] cur_sp;
        bit [15:0] centre;

        duty_result_t expected_duty[$];
        int failures;
        int reported;

        function new();
            scan_points  = 10'd168;
            timer_period = 16'd1000;
            pulse_max    = 16'd950;
            pulse_min    = 16'd0;
            mode         = MODE_IDLE;
            phase        = PH_CENTER;
            scan_idx     = '0;
            scan_end     = '0;
            step         = '0;
            best_idx     = '0;
            best_power   = '0;
            power_centre = '0;
            power_up     = '0;
            cur_sp       = 16'd288;
            centre       = 16'd288;
            failures     = 0;
            reported     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_SCAN_POINTS:  scan_points  = val[9:0];
                CFG_TIMER_PERIOD: timer_period = val;
                CFG_PULSE_MAX:    pulse_max    = val;
                default:          pulse_min    = val;
            endcase
        endfunction

        // Timer compare value: clamped in full precision, the lower clamp winning.
        function bit [15:0] pulse_for(bit [15:0] sp);
            bit [31:0] p;
            p = (32'(sp) * 32'(timer_period)) / 32'd1000;
            if (p > 32'(pulse_max))
                p = 32'(pulse_max);
            if (p < 32'(pulse_min))
                p = 32'(pulse_min);
            return p[15:0];
        endfunction

        function void emit_duty(bit [15:0] sp, bit wants);
            duty_result_t r;
            cur_sp          = sp;
            r.setpoint      = sp;
            r.pulse         = pulse_for(sp);
            r.wants_measure = wants;
            r.last          = 1'b0;
            expected_duty.push_back(r);
        endfunction

        // Either the next sweep point, or the end of the sweep at the best index so far.
        function void next_scan_point();
            bit [31:0] prod;
            if (scan_idx < scan_end)
            begin
                prod = 32'(scan_idx) * 32'(step);
                emit_duty(prod[15:0], 1'b1);
            end
            else
            begin
                mode = MODE_IDLE;
                prod = 32'(best_idx) * 32'(step);
                emit_duty(prod[15:0], 1'b0);
            end
        endfunction

        function void note_transaction(logic [1:0] action, logic signed [15:0] power);
            int        before_n;
            bit [9:0]  pts;
            bit [15:0] down;
            before_n = expected_duty.size();
            case (action)
                ACT_SCAN:
                begin
                    // A point count of zero behaves as one.
                    pts        = (scan_points == 10'd0) ? 10'd1 : scan_points;
                    step       = 10'(32'd1000 / 32'(pts));
                    scan_end   = pts / 10'd3;
                    scan_idx   = 10'd5;
                    best_power = '0;
                    mode       = MODE_SCAN;
                    next_scan_point();
                end
                ACT_LOCAL:
                begin
                    centre = cur_sp;
                    phase  = PH_CENTER;
                    mode   = MODE_LOCAL;
                    emit_duty(centre, 1'b1);
                end
                ACT_MEASURE:
                begin
                    if (mode == MODE_SCAN)
                    begin
                        // Only a strictly larger power moves the best index.
                        if (power > best_power)
                        begin
                            best_power = power;
                            best_idx   = scan_idx;
                        end
                        scan_idx = scan_idx + 10'd1;
                        next_scan_point();
                    end
                    else if (mode == MODE_LOCAL)
                    begin
                        case (phase)
                            PH_CENTER:
                            begin
                                power_centre = power;
                                phase        = PH_UP;
                                emit_duty(centre + 16'd8, 1'b1);
                            end
                            PH_UP:
                            begin
                                down     = (centre < 16'd34) ? 16'd18 : centre - 16'd8;
                                power_up = power;
                                phase    = PH_DOWN;
                                emit_duty(down, 1'b1);
                            end
                            default:
                            begin
                                mode  = MODE_IDLE;
                                phase = PH_CENTER;
                                emit_duty(centre, 1'b0);
                                if (power_centre < power)
                                    emit_duty(centre - 16'd1, 1'b0);
                                if (power_centre < power_up)
                                    emit_duty(centre + 16'd1, 1'b0);
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            if (expected_duty.size() > before_n)
                expected_duty[expected_duty.size() - 1].last = 1'b1;
        endfunction

        function void check_duty(logic [15:0] sp, logic [15:0] pulse, logic wants,
                                 logic last);
            duty_result_t e;
            if (expected_duty.size() == 0)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("unexpected result: setpoint=%0d pulse=%0d wants_measure=%0b last=%0b",
                             sp, pulse, wants, last);
                end
                return;
            end
            e = expected_duty.pop_front();
            if (e.setpoint !== sp || e.pulse !== pulse || e.wants_measure !== wants
                || e.last !== last)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("mismatch: expected setpoint=%0d pulse=%0d wants_measure=%0b last=%0b",
                             e.setpoint, e.pulse, e.wants_measure, e.last);
                    $display("          actual   setpoint=%0d pulse=%0d wants_measure=%0b last=%0b",
                             sp, pulse, wants, last);
                end
            end
        endfunction

        function int pending();
            return expected_duty.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] power (signed)
    logic [1:0]  s_axis_tuser = '0;    // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] setpoint, [31:16] pulse
    logic [0:0]  m_axis_tuser;         // [0] wants_measure
    logic        m_axis_tlast;

    mppt_scoreboard sb;
    int unsigned    cycle_count = 0;
    int             idle_pct = IDLE_PCT;
    // Transactions that the core acts upon; ignored ones are left out of this count.
    int             useful_items = 0;

    mppt_sweep_and_hill_climb_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side. Outputs are sampled at the edge, before any register update of that
    // edge lands, and tready is stalled at random in the same proportion as the sender.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_duty(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0],
                          m_axis_tlast);
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Offers one input transaction after a random gap and returns at the edge that accepts
    // it. tvalid stays high on return so that back-to-back transactions need no dip.
    task automatic send_transaction(logic [1:0] action, logic [15:0] power);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= power;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (action == ACT_SCAN || action == ACT_LOCAL
            || (action == ACT_MEASURE && sb.mode != MODE_IDLE))
            useful_items++;
        sb.note_transaction(action, power);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_settings(logic [15:0] points, logic [15:0] period,
                                 logic [15:0] pmax, logic [15:0] pmin);
        write_reg(CFG_SCAN_POINTS, points);
        write_reg(CFG_TIMER_PERIOD, period);
        write_reg(CFG_PULSE_MAX, pmax);
        write_reg(CFG_PULSE_MIN, pmin);
        cfg_we <= 1'b0;
    endtask

    // Waits until every expected result has arrived, then long enough for a transaction
    // that causes no result to have left the core as well.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Power for a sweep: full-range values, small values around zero and the extremes.
    function automatic logic [15:0] any_power();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom);
            2:       return 16'($urandom_range(0, 40)) - 16'd20;
            default:
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h0000;
                    default: return 16'hffff;
                endcase
        endcase
    endfunction

    // Power for a local step: mostly a few small values so that ties and every
    // combination of better-down and better-up are common.
    function automatic logic [15:0] local_power();
        if ($urandom_range(0, 3) == 0)
            return any_power();
        return 16'($urandom_range(0, 3));
    endfunction

    // Random traffic: mostly complete sweeps and local steps with random powers, some of
    // them cut short and restarted, plus a share of stray transactions of any action.
    task automatic run_traffic(int target);
        int start_count;
        int cap;
        int n;
        int k;
        int pick;
        start_count = useful_items;
        while (useful_items - start_count < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_transaction(ACT_SCAN, 16'($urandom));
                cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 60;
                n = 0;
                while (sb.mode == MODE_SCAN && n < cap
                       && useful_items - start_count < target)
                begin
                    send_transaction(ACT_MEASURE, any_power());
                    n++;
                end
            end
            else if (pick < 85)
            begin
                send_transaction(ACT_LOCAL, 16'($urandom));
                k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
                repeat (k)
                    send_transaction(ACT_MEASURE, local_power());
            end
            else
            begin
                send_transaction(2'($urandom_range(0, 3)), any_power());
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with a single scan point so that every sweep is empty.
        // A measurement while idle and the unused action must give nothing; the empty
        // sweep lands on setpoint zero, and the local step around zero then uses the
        // floored low probe and wraps below zero when stepping down.
        load_settings(16'd1, 16'd1000, 16'd950, 16'd0);
        send_transaction(ACT_MEASURE, 16'd1234);
        send_transaction(ACT_UNUSED, 16'hffff);
        send_transaction(ACT_SCAN, 16'd0);
        send_transaction(ACT_LOCAL, 16'd0);
        send_transaction(ACT_MEASURE, 16'd0);
        send_transaction(ACT_MEASURE, 16'd5);
        send_transaction(ACT_MEASURE, 16'd5);

        // Two-point sweeps with the widest period: no positive power keeps the stale best
        // index, the most positive power wins, and a sweep is abandoned by a local step
        // whose three probes tie.
        settle();
        load_settings(16'd21, 16'hffff, 16'hffff, 16'd0);
        send_transaction(ACT_SCAN, 16'd0);
        send_transaction(ACT_MEASURE, 16'hfffb);
        send_transaction(ACT_MEASURE, 16'd0);
        send_transaction(ACT_SCAN, 16'd0);
        send_transaction(ACT_MEASURE, 16'h7fff);
        send_transaction(ACT_MEASURE, 16'd100);
        send_transaction(ACT_SCAN, 16'd0);
        send_transaction(ACT_MEASURE, 16'h8000);
        send_transaction(ACT_LOCAL, 16'd0);
        send_transaction(ACT_MEASURE, 16'd7);
        send_transaction(ACT_MEASURE, 16'd7);
        send_transaction(ACT_MEASURE, 16'd7);

        // Crossed clamps with a point count of 1000; a restart lands on a low centre.
        settle();
        load_settings(16'd1000, 16'd1, 16'd100, 16'd200);
        send_transaction(ACT_SCAN, 16'd0);
        send_transaction(ACT_MEASURE, 16'd1);
        send_transaction(ACT_LOCAL, 16'd0);
        send_transaction(ACT_MEASURE, 16'hffff);
        send_transaction(ACT_MEASURE, 16'hfffe);
        send_transaction(ACT_MEASURE, 16'hfffd);

        // Random phases, each under its own configuration.
        settle();
        load_settings(16'd168, 16'd1000, 16'd950, 16'd0);
        run_traffic(88);

        settle();
        load_settings(16'($urandom_range(1, 14)), 16'hffff, 16'hffff, 16'd0);
        run_traffic(88);

        // This phase runs with no idling on either side.
        settle();
        idle_pct = 0;
        load_settings(16'd1000, 16'd1, 16'd0, 16'hffff);
        run_traffic(88);

        settle();
        idle_pct = IDLE_PCT;
        load_settings(16'($urandom_range(15, 60)), 16'($urandom_range(1, 65535)),
                      16'($urandom), 16'($urandom));
        run_traffic(88);

        settle();
        load_settings(16'd0, 16'($urandom_range(500, 3000)), 16'($urandom_range(0, 3000)),
                      16'($urandom_range(0, 1500)));
        run_traffic(88);

        settle();
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
